@@ rtl/tsmm_pkg.sv @@
// Shared types and constants for the thermistor scan block.
`default_nettype none

package tsmm_pkg;

    localparam int TEMP_W  = 8;
    localparam int CH_W    = 4;
    localparam int SUM_W   = 12;
    localparam int FTOT_W  = 5;
    localparam int CFG_W   = 8;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SAFE_LOW  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAFE_HIGH = 1'd1;

    localparam logic signed [TEMP_W-1:0] SAFE_LOW_RST  = -8'sd40;
    localparam logic signed [TEMP_W-1:0] SAFE_HIGH_RST = 8'sd125;

    // Aggregate starting values at each frame start.
    localparam logic signed [TEMP_W-1:0] START_MIN = 8'sd125;
    localparam logic signed [TEMP_W-1:0] START_MAX = -8'sd40;

    // Per-request tag that travels alongside the temperature.
    typedef struct packed {
        logic [CH_W-1:0] channel;
        logic            first;
        logic            last;
    } t_item;

endpackage

`default_nettype wire

@@ rtl/tsmm_conv.sv @@
// Code-to-temperature ROM with a registered read port and its stage valid.
`default_nettype none

module tsmm_conv
    import tsmm_pkg::*;
#(
    parameter int ADC_BITS     = 12,
    parameter int VREF_MV      = 3300,
    parameter int SUPPLY_MV    = 3300,
    parameter int DIVIDER_OHMS = 10000,
    parameter int NOMINAL_OHMS = 10000
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    input  wire logic [ADC_BITS-1:0]      i_code,
    input  wire t_item                    i_item,
    input  wire logic                     i_adv,
    output logic                          o_load,
    output logic                          o_valid,
    output logic signed [TEMP_W-1:0]      o_temp,
    output t_item                         o_item
);

    localparam int DEPTH = 1 << ADC_BITS;

    localparam logic [63:0]        LN2Q      = 64'd2977044472;
    localparam logic signed [63:0] DEN_BASE  = 64'sd1690 <<< 32;
    localparam logic signed [63:0] DEN_SLOPE = 64'sd149;
    localparam logic [63:0]        NUM_Q     = 64'd50362000 << 32;
    localparam logic signed [63:0] OFS_CENTI = 64'sd27265;

    // ln(n) in Q32: integer log2 plus 32 fraction bits by repeated squaring.
    function automatic logic [63:0] lnq(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] m;
        logic [63:0] f;
        int          e;
        n = (n_in == 64'd0) ? 64'd1 : n_in;
        e = 0;
        f = 64'd0;
        for (int k = 0; k < 64; k++) begin
            if (n[k]) begin
                e = k;
            end
        end
        m = (e >= 31) ? (n >> (e - 31)) : (n << (31 - e));
        for (int k = 0; k < 32; k++) begin
            m = (m * m) >> 31;
            f = {f[62:0], 1'b0};
            if (m[32]) begin
                m    = m >> 1;
                f[0] = 1'b1;
            end
        end
        return (64'(e) * LN2Q) + ((f * LN2Q) >> 32);
    endfunction

    // Restoring long division, evaluated only while building the ROM.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] r;
        logic [63:0] q;
        r = 65'd0;
        q = 64'd0;
        for (int k = 63; k >= 0; k--) begin
            r = {r[63:0], num[k]};
            if (r >= {1'b0, den}) begin
                r    = r - {1'b0, den};
                q[k] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic signed [TEMP_W-1:0] conv_temp(input logic [ADC_BITS-1:0] code);
        logic [63:0]        v;
        logic [63:0]        la;
        logic [63:0]        lb;
        logic signed [63:0] l;
        logic signed [63:0] d;
        logic signed [63:0] x;
        logic signed [63:0] t;
        v = (64'(code) * 64'(VREF_MV)) >> ADC_BITS;
        if (v == 64'd0 || v >= 64'(SUPPLY_MV)) begin
            return -8'sd128;
        end
        la = lnq(v * 64'(DIVIDER_OHMS));
        lb = lnq((64'(SUPPLY_MV) - v) * 64'(NOMINAL_OHMS));
        l  = $signed(la) - $signed(lb);
        d  = DEN_BASE + DEN_SLOPE * l;
        if (d <= 64'sd0) begin
            return -8'sd128;
        end
        x = $signed(udiv64(NUM_Q, $unsigned(d))) - OFS_CENTI;
        // Floor division by 100 (rounds the hundredths toward minus infinity).
        t = (x >= 64'sd0) ? (x / 64'sd100) : -((-x + 64'sd99) / 64'sd100);
        if (t > 64'sd127) begin
            t = 64'sd127;
        end
        if (t < -64'sd128) begin
            t = -64'sd128;
        end
        return TEMP_W'(t);
    endfunction

    logic signed [TEMP_W-1:0] w_rom [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_rom
        localparam logic signed [TEMP_W-1:0] ENTRY = conv_temp(ADC_BITS'(g));
        assign w_rom[g] = ENTRY;
    end

    logic                     r_valid;
    logic signed [TEMP_W-1:0] r_temp;
    t_item                    r_item;

    // Load the read register when it is empty or its content moves on.
    assign o_load = !r_valid || i_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load && i_valid) begin
            r_temp <= w_rom[i_code];
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_temp  = r_temp;
    assign o_item  = r_item;

endmodule

`default_nettype wire

@@ rtl/tsmm_agg.sv @@
// Window check, clamp and running frame aggregates, with the output register.
`default_nettype none

module tsmm_agg
    import tsmm_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    input  wire logic signed [TEMP_W-1:0] i_temp,
    input  wire t_item                    i_item,
    input  wire logic signed [TEMP_W-1:0] i_safe_low,
    input  wire logic signed [TEMP_W-1:0] i_safe_high,
    input  wire logic                     i_stall,
    output logic                          o_adv,
    output logic                          o_valid,
    output logic [CH_W-1:0]               o_channel,
    output logic signed [TEMP_W-1:0]      o_temperature,
    output logic                          o_fault,
    output logic                          o_frame_done,
    output logic signed [TEMP_W-1:0]      o_lowest_temp,
    output logic [CH_W-1:0]               o_min_channel,
    output logic signed [TEMP_W-1:0]      o_highest_temp,
    output logic [CH_W-1:0]               o_max_channel,
    output logic signed [SUM_W-1:0]       o_temp_sum,
    output logic [FTOT_W-1:0]             o_fault_total
);

    localparam logic signed [SUM_W:0]  SUM_HI  = (SUM_W+1)'(2 ** (SUM_W - 1) - 1);
    localparam logic signed [SUM_W:0]  SUM_LO  = -(SUM_W+1)'(2 ** (SUM_W - 1));
    localparam logic [FTOT_W-1:0]      FT_TOP  = '1;

    logic                     r_valid;
    logic [CH_W-1:0]          r_channel;
    logic signed [TEMP_W-1:0] r_temp;
    logic                     r_fault;
    logic                     r_done;
    logic signed [TEMP_W-1:0] r_min;
    logic [CH_W-1:0]          r_min_ch;
    logic signed [TEMP_W-1:0] r_max;
    logic [CH_W-1:0]          r_max_ch;
    logic signed [SUM_W-1:0]  r_sum;
    logic [FTOT_W-1:0]        r_ftot;

    logic signed [TEMP_W-1:0] n_temp;
    logic                     n_fault;
    logic signed [TEMP_W-1:0] n_min;
    logic [CH_W-1:0]          n_min_ch;
    logic signed [TEMP_W-1:0] n_max;
    logic [CH_W-1:0]          n_max_ch;
    logic signed [SUM_W-1:0]  n_sum;
    logic [FTOT_W-1:0]        n_ftot;
    logic signed [SUM_W:0]    w_sum_wide;
    logic                     w_below;
    logic                     w_above;

    assign o_adv = !r_valid || !i_stall;

    always_comb begin
        // Restart the aggregates at channel 0, else continue from the last result.
        n_min    = i_item.first ? START_MIN : r_min;
        n_min_ch = i_item.first ? '0 : r_min_ch;
        n_max    = i_item.first ? START_MAX : r_max;
        n_max_ch = i_item.first ? '0 : r_max_ch;
        n_sum    = i_item.first ? '0 : r_sum;
        n_ftot   = i_item.first ? '0 : r_ftot;

        w_below    = i_temp < i_safe_low;
        w_above    = i_temp > i_safe_high;
        n_fault    = w_below || w_above;
        n_temp     = i_temp;
        w_sum_wide = {n_sum[SUM_W-1], n_sum} + (SUM_W+1)'(i_temp);

        if (n_fault) begin
            n_temp = w_below ? i_safe_low : i_safe_high;
            if (n_ftot != FT_TOP) begin
                n_ftot = n_ftot + 1'b1;
            end
        end else begin
            if (i_temp < n_min) begin
                n_min    = i_temp;
                n_min_ch = i_item.channel;
            end
            if (i_temp > n_max) begin
                n_max    = i_temp;
                n_max_ch = i_item.channel;
            end
            if (w_sum_wide > SUM_HI) begin
                n_sum = SUM_HI[SUM_W-1:0];
            end else if (w_sum_wide < SUM_LO) begin
                n_sum = SUM_LO[SUM_W-1:0];
            end else begin
                n_sum = w_sum_wide[SUM_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_min    <= START_MIN;
            r_min_ch <= '0;
            r_max    <= START_MAX;
            r_max_ch <= '0;
            r_sum    <= '0;
            r_ftot   <= '0;
        end else if (o_adv) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_min    <= n_min;
                r_min_ch <= n_min_ch;
                r_max    <= n_max;
                r_max_ch <= n_max_ch;
                r_sum    <= n_sum;
                r_ftot   <= n_ftot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && i_valid) begin
            r_channel <= i_item.channel;
            r_temp    <= n_temp;
            r_fault   <= n_fault;
            r_done    <= i_item.last;
        end
    end

    assign o_valid        = r_valid;
    assign o_channel      = r_channel;
    assign o_temperature  = r_temp;
    assign o_fault        = r_fault;
    assign o_frame_done   = r_done;
    assign o_lowest_temp  = r_min;
    assign o_min_channel  = r_min_ch;
    assign o_highest_temp = r_max;
    assign o_max_channel  = r_max_ch;
    assign o_temp_sum     = r_sum;
    assign o_fault_total  = r_ftot;

endmodule

`default_nettype wire

@@ rtl/thermistor_scan_min_max_fault_top.sv @@
// Top level of the thermistor scanner with frame min, max, sum and fault count.
//
//  Channel   Direction  Handshake            Payload
//  ------    ---------  -------------------  ----------------------------------------
//  input     in         i_valid / o_stall    i_raw_code
//  output    out        o_valid / i_stall    o_channel, o_temperature, o_fault,
//                                            o_frame_done, o_lowest_temp, o_min_channel,
//                                            o_highest_temp, o_max_channel, o_temp_sum,
//                                            o_fault_total
//  config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// One request per cycle while i_stall is low; each request passes from acceptance to
// its result through the ROM read register, then the aggregate/output register.
// The rate is set by the single read port of the code-to-temperature ROM.
// Reset is synchronous on i_rst_n low: channel counter to 0, aggregates to their
// frame-start values, safe window to -40..125, both stages empty.
// A stalled result holds in the output register; the ROM stage still takes one more
// request, and o_stall rises only when both stages are full and i_stall is high.
`default_nettype none

module thermistor_scan_min_max_fault_top
    import tsmm_pkg::*;
#(
    parameter int NUM_CHANNELS = 16,
    parameter int ADC_BITS     = 12,
    parameter int VREF_MV      = 3300,
    parameter int SUPPLY_MV    = 3300,
    parameter int DIVIDER_OHMS = 10000,
    parameter int NOMINAL_OHMS = 10000
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic [ADC_BITS-1:0]      i_raw_code,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic [CH_W-1:0]               o_channel,
    output logic signed [TEMP_W-1:0]      o_temperature,
    output logic                          o_fault,
    output logic                          o_frame_done,
    output logic signed [TEMP_W-1:0]      o_lowest_temp,
    output logic [CH_W-1:0]               o_min_channel,
    output logic signed [TEMP_W-1:0]      o_highest_temp,
    output logic [CH_W-1:0]               o_max_channel,
    output logic signed [SUM_W-1:0]       o_temp_sum,
    output logic [FTOT_W-1:0]             o_fault_total,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [CFG_W-1:0]         i_cfg_data
);

    localparam int CNT_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_CHANNELS - 1);

    logic [CNT_W-1:0]         r_cnt;
    logic [CNT_W-1:0]         n_cnt;
    logic signed [TEMP_W-1:0] r_safe_low;
    logic signed [TEMP_W-1:0] r_safe_high;

    logic                     w_accept;
    logic                     w_load;
    logic                     w_adv;
    logic                     w_s1_valid;
    logic signed [TEMP_W-1:0] w_s1_temp;
    t_item                    w_s1_item;
    t_item                    w_item;

    // Tag the request with its channel; the counter wraps at the frame end.
    assign w_item.channel = CH_W'(r_cnt);
    assign w_item.first   = (r_cnt == '0);
    assign w_item.last    = (r_cnt == CNT_LAST);

    assign o_stall  = !w_load;
    assign w_accept = i_valid && w_load;
    assign n_cnt    = w_item.last ? '0 : r_cnt + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_accept) begin
            r_cnt <= n_cnt;
        end
    end

    // Safe window registers; writes to unknown indexes drop.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_safe_low  <= SAFE_LOW_RST;
            r_safe_high <= SAFE_HIGH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SAFE_LOW:  r_safe_low  <= i_cfg_data;
                REG_SAFE_HIGH: r_safe_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tsmm_conv #(
        .ADC_BITS     (ADC_BITS),
        .VREF_MV      (VREF_MV),
        .SUPPLY_MV    (SUPPLY_MV),
        .DIVIDER_OHMS (DIVIDER_OHMS),
        .NOMINAL_OHMS (NOMINAL_OHMS)
    ) u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_code  (i_raw_code),
        .i_item  (w_item),
        .i_adv   (w_adv),
        .o_load  (w_load),
        .o_valid (w_s1_valid),
        .o_temp  (w_s1_temp),
        .o_item  (w_s1_item)
    );

    tsmm_agg u_agg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_s1_valid),
        .i_temp         (w_s1_temp),
        .i_item         (w_s1_item),
        .i_safe_low     (r_safe_low),
        .i_safe_high    (r_safe_high),
        .i_stall        (i_stall),
        .o_adv          (w_adv),
        .o_valid        (o_valid),
        .o_channel      (o_channel),
        .o_temperature  (o_temperature),
        .o_fault        (o_fault),
        .o_frame_done   (o_frame_done),
        .o_lowest_temp  (o_lowest_temp),
        .o_min_channel  (o_min_channel),
        .o_highest_temp (o_highest_temp),
        .o_max_channel  (o_max_channel),
        .o_temp_sum     (o_temp_sum),
        .o_fault_total  (o_fault_total)
    );

`ifndef SYNTHESIS
    // Input stalls only while both stages hold requests.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (w_s1_valid && o_valid))
        else $error("input stalled with a free stage");

    // A good result lies inside the window and inside the frame min/max.
    a_good_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_fault) |-> (o_temperature >= r_safe_low &&
            o_temperature <= r_safe_high && o_lowest_temp <= o_temperature &&
            o_highest_temp >= o_temperature))
        else $error("good temperature not reflected in window or aggregates");

    // Frame end marks the last channel.
    a_done_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_done) |-> (o_channel == CH_W'(NUM_CHANNELS - 1)))
        else $error("frame end on wrong channel");

    // Channel counter stays inside the frame.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) < NUM_CHANNELS)
        else $error("channel counter out of range");
`endif

endmodule

`default_nettype wire
